FILE: src/srec_pkg.sv
// -----------------------------------------------------------------------------
// srec_pkg
// Shared types, character codes and helpers for the S-record parser.
// -----------------------------------------------------------------------------
`default_nettype none

package srec_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_S       = 8'h53;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] BYTE_ONES    = 8'hFF;

   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_ERROR   = 2'd2,
      KIND_SUMMARY = 2'd3
   } kind_type;

   // classified character handed from front to back
   typedef struct packed {
      logic       eof;
      logic       is_s;
      logic       is_newline;
      logic       is_hex;
      logic [3:0] hex_value;
      logic [1:0] rec_size;    // 1..3 for record types S1..S3, else 0
   } token_type;

   typedef struct packed {
      logic stopped;
      logic at_line_start;
   } back_status_type;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
         return {1'b1, d[3:0]};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         d = c - CHAR_UPPER_A + 8'd10;
         return {1'b1, d[3:0]};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         d = c - CHAR_LOWER_A + 8'd10;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

`default_nettype wire

FILE: src/srec_if.sv
// -----------------------------------------------------------------------------
// srec_if
// Valid/ready channels for the character stream and the parser results.
// -----------------------------------------------------------------------------
`default_nettype none

interface srec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_file;

   modport source (output valid, output char_code, output end_of_file, input ready);
   modport sink   (input valid, input char_code, input end_of_file, output ready);
endinterface

interface srec_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] write_address;
   logic [7:0]  write_data;
   logic [31:0] min_address;
   logic [31:0] max_address;
   logic        range_seen;
   logic        failed;

   modport source (output valid, output kind, output write_address, output write_data,
                   output min_address, output max_address, output range_seen,
                   output failed, input ready);
   modport sink   (input valid, input kind, input write_address, input write_data,
                   input min_address, input max_address, input range_seen,
                   input failed, output ready);
endinterface

`default_nettype wire

FILE: src/srec_front.sv
// -----------------------------------------------------------------------------
// srec_front
// Accepts characters and classifies them into tokens for the queue.
// -----------------------------------------------------------------------------
`default_nettype none

module srec_front (
   srec_req_if.sink                req_chan,
   input  wire logic               queue_full,
   output srec_pkg::token_type     push_token,
   output logic                    push_valid
);

   logic [4:0] hex_info;

   always_comb begin
      hex_info               = srec_pkg::hex_decode(req_chan.char_code);
      push_token.eof         = req_chan.end_of_file;
      push_token.is_s        = (req_chan.char_code == srec_pkg::CHAR_S);
      push_token.is_newline  = (req_chan.char_code == srec_pkg::CHAR_NEWLINE);
      push_token.is_hex      = hex_info[4];
      push_token.hex_value   = hex_info[3:0];
      push_token.rec_size    = 2'd0;
      if (hex_info[4] && hex_info[3:0] >= 4'd1 && hex_info[3:0] <= 4'd3
          && req_chan.char_code <= srec_pkg::CHAR_NINE) begin
         push_token.rec_size = hex_info[1:0];
      end
   end

   assign req_chan.ready = !queue_full;
   assign push_valid     = req_chan.valid && !queue_full;

endmodule

`default_nettype wire

FILE: src/srec_queue.sv
// -----------------------------------------------------------------------------
// srec_queue
// Small token queue between the front and back parts.
// -----------------------------------------------------------------------------
`default_nettype none

module srec_queue #(
   parameter int Depth = srec_pkg::QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  wire srec_pkg::token_type             push_token,
   input  wire logic                            pop,
   output srec_pkg::token_type                  head_token,
   output logic                                 full,
   output logic                                 not_empty,
   output logic [$clog2(Depth + 1) - 1:0]       level
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int LvlW = $clog2(Depth + 1);

   srec_pkg::token_type entry_ff [Depth];
   logic [PtrW - 1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW - 1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LvlW - 1:0]   count_ff, count_in;

   function automatic logic [PtrW - 1:0] bump(input logic [PtrW - 1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = (count_ff == LvlW'(Depth));
   assign not_empty  = (count_ff != '0);
   assign head_token = entry_ff[rd_ptr_ff];
   assign level      = count_ff;

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

`default_nettype wire

FILE: src/srec_back.sv
// -----------------------------------------------------------------------------
// srec_back
// Record state machine: fields, writes, checksum, range and result register.
// -----------------------------------------------------------------------------
`default_nettype none

module srec_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tok_valid,
   input  wire srec_pkg::token_type  tok,
   output logic                      tok_pop,
   output srec_pkg::back_status_type status,
   srec_rsp_if.source                rsp_chan
);

   typedef enum logic [2:0] {
      PH_LINE, PH_TYPE, PH_COUNT, PH_ADDR, PH_DATA, PH_CSUM, PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  addr_size_ff, addr_size_in;
   logic [3:0]  digit_count_ff, digit_count_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] cur_address_ff, cur_address_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  sum_ff, sum_in;
   logic [31:0] range_low_ff, range_low_in;
   logic [31:0] range_high_ff, range_high_in;
   logic        any_range_ff, any_range_in;
   logic        stopped_ff, stopped_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [31:0] out_waddr_ff, out_waddr_in;
   logic [7:0]  out_wdata_ff, out_wdata_in;
   logic [31:0] out_low_ff, out_low_in;
   logic [31:0] out_high_ff, out_high_in;
   logic        out_seen_ff, out_seen_in;
   logic        out_failed_ff, out_failed_in;

   logic        advance;
   logic [31:0] acc_new;
   logic [3:0]  cnt_new;
   logic [2:0]  abytes;
   logic [3:0]  need;
   logic [7:0]  byte_new;
   logic [31:0] last_addr;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign tok_pop = tok_valid && advance;

   always_comb begin
      phase_in       = phase_ff;
      addr_size_in   = addr_size_ff;
      digit_count_in = digit_count_ff;
      accum_in       = accum_ff;
      cur_address_in = cur_address_ff;
      bytes_left_in  = bytes_left_ff;
      sum_in         = sum_ff;
      range_low_in   = range_low_ff;
      range_high_in  = range_high_ff;
      any_range_in   = any_range_ff;
      stopped_in     = stopped_ff;

      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_kind_in    = out_kind_ff;
      out_waddr_in   = out_waddr_ff;
      out_wdata_in   = out_wdata_ff;
      out_low_in     = out_low_ff;
      out_high_in    = out_high_ff;
      out_seen_in    = out_seen_ff;
      out_failed_in  = out_failed_ff;

      acc_new   = {accum_ff[27:0], tok.hex_value};
      cnt_new   = digit_count_ff + 4'd1;
      abytes    = {1'b0, addr_size_ff} + 3'd1;
      need      = (phase_ff == PH_ADDR) ? {abytes, 1'b0} : 4'd2;
      byte_new  = acc_new[7:0];
      last_addr = acc_new + {24'd0, bytes_left_ff - 8'd1};

      if (tok_pop) begin
         if (tok.eof) begin
            out_valid_in   = 1'b1;
            out_kind_in    = srec_pkg::KIND_SUMMARY;
            out_waddr_in   = '0;
            out_wdata_in   = '0;
            out_low_in     = range_low_ff;
            out_high_in    = range_high_ff;
            out_seen_in    = any_range_ff;
            out_failed_in  = stopped_ff;
            phase_in       = PH_LINE;
            addr_size_in   = '0;
            digit_count_in = '0;
            accum_in       = '0;
            cur_address_in = '0;
            bytes_left_in  = '0;
            sum_in         = '0;
            range_low_in   = '0;
            range_high_in  = '0;
            any_range_in   = 1'b0;
            stopped_in     = 1'b0;
         end else if (!stopped_ff) begin
            unique case (phase_ff) inside
               PH_LINE: begin
                  if (tok.is_s) begin
                     phase_in = PH_TYPE;
                  end else if (!tok.is_newline) begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_TYPE: begin
                  if (tok.rec_size != 2'd0) begin
                     addr_size_in   = tok.rec_size;
                     sum_in         = '0;
                     digit_count_in = '0;
                     accum_in       = '0;
                     phase_in       = PH_COUNT;
                  end else if (tok.is_newline) begin
                     phase_in = PH_LINE;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  if (tok.is_newline) begin
                     phase_in = PH_LINE;
                  end
               end
               PH_COUNT, PH_ADDR, PH_DATA, PH_CSUM: begin
                  if (!tok.is_hex) begin
                     stopped_in    = 1'b1;
                     out_valid_in  = 1'b1;
                     out_kind_in   = srec_pkg::KIND_ERROR;
                     out_waddr_in  = '0;
                     out_wdata_in  = '0;
                     out_low_in    = '0;
                     out_high_in   = '0;
                     out_seen_in   = 1'b0;
                     out_failed_in = 1'b1;
                  end else begin
                     accum_in       = acc_new;
                     digit_count_in = cnt_new;
                     // each completed byte before the checksum byte joins the checksum
                     if (!cnt_new[0] && phase_ff != PH_CSUM) begin
                        sum_in = sum_ff + byte_new;
                     end
                     if (cnt_new >= need) begin
                        digit_count_in = '0;
                        accum_in       = '0;
                        unique case (phase_ff)
                           PH_COUNT: begin
                              bytes_left_in = (byte_new >= {5'd0, abytes} + 8'd1)
                                            ? byte_new - {5'd0, abytes} - 8'd1 : 8'd0;
                              phase_in      = PH_ADDR;
                           end
                           PH_ADDR: begin
                              cur_address_in = acc_new;
                              if (bytes_left_ff != 8'd0) begin
                                 if (!any_range_ff) begin
                                    range_low_in  = acc_new;
                                    range_high_in = last_addr;
                                    any_range_in  = 1'b1;
                                 end else begin
                                    if (acc_new < range_low_ff) begin
                                       range_low_in = acc_new;
                                    end
                                    if (last_addr > range_high_ff) begin
                                       range_high_in = last_addr;
                                    end
                                 end
                                 phase_in = PH_DATA;
                              end else begin
                                 phase_in = PH_CSUM;
                              end
                           end
                           PH_DATA: begin
                              out_valid_in   = 1'b1;
                              out_kind_in    = srec_pkg::KIND_WRITE;
                              out_waddr_in   = cur_address_ff;
                              out_wdata_in   = byte_new;
                              out_low_in     = '0;
                              out_high_in    = '0;
                              out_seen_in    = 1'b0;
                              out_failed_in  = 1'b0;
                              cur_address_in = cur_address_ff + 32'd1;
                              bytes_left_in  = bytes_left_ff - 8'd1;
                              phase_in = (bytes_left_ff == 8'd1) ? PH_CSUM : PH_DATA;
                           end
                           default: begin
                              out_valid_in  = 1'b1;
                              out_waddr_in  = '0;
                              out_wdata_in  = '0;
                              out_low_in    = '0;
                              out_high_in   = '0;
                              out_seen_in   = 1'b0;
                              if (byte_new == (sum_ff ^ srec_pkg::BYTE_ONES)) begin
                                 out_kind_in   = srec_pkg::KIND_GOOD;
                                 out_failed_in = 1'b0;
                                 phase_in      = PH_SKIP;
                              end else begin
                                 out_kind_in    = srec_pkg::KIND_ERROR;
                                 out_failed_in  = 1'b1;
                                 stopped_in     = 1'b1;
                                 digit_count_in = cnt_new;
                                 accum_in       = acc_new;
                              end
                           end
                        endcase
                     end
                  end
               end
               default: phase_in = PH_LINE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LINE;
         addr_size_ff   <= '0;
         digit_count_ff <= '0;
         accum_ff       <= '0;
         cur_address_ff <= '0;
         bytes_left_ff  <= '0;
         sum_ff         <= '0;
         range_low_ff   <= '0;
         range_high_ff  <= '0;
         any_range_ff   <= 1'b0;
         stopped_ff     <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         addr_size_ff   <= addr_size_in;
         digit_count_ff <= digit_count_in;
         accum_ff       <= accum_in;
         cur_address_ff <= cur_address_in;
         bytes_left_ff  <= bytes_left_in;
         sum_ff         <= sum_in;
         range_low_ff   <= range_low_in;
         range_high_ff  <= range_high_in;
         any_range_ff   <= any_range_in;
         stopped_ff     <= stopped_in;
         out_valid_ff   <= out_valid_in;
      end
      out_kind_ff   <= out_kind_in;
      out_waddr_ff  <= out_waddr_in;
      out_wdata_ff  <= out_wdata_in;
      out_low_ff    <= out_low_in;
      out_high_ff   <= out_high_in;
      out_seen_ff   <= out_seen_in;
      out_failed_ff <= out_failed_in;
   end

   assign status.stopped       = stopped_ff;
   assign status.at_line_start = (phase_ff == PH_LINE);

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_kind_ff;
   assign rsp_chan.write_address = out_waddr_ff;
   assign rsp_chan.write_data    = out_wdata_ff;
   assign rsp_chan.min_address   = out_low_ff;
   assign rsp_chan.max_address   = out_high_ff;
   assign rsp_chan.range_seen    = out_seen_ff;
   assign rsp_chan.failed        = out_failed_ff;

endmodule

`default_nettype wire

FILE: src/srec_record_parser_core.sv
// -----------------------------------------------------------------------------
// srec_record_parser_core
// S-record text parser: emits memory writes, record status and a range summary.
//
//   channel    dir   transfer carries
//   req_chan   in    char_code, end_of_file
//   rsp_chan   out   kind, write_address, write_data, min/max_address,
//                    range_seen, failed
//
// one character per cycle while no result stalls; a result passes through the
// queue, then the state machine into the result register
// synchronous reset returns the parser to line start with an empty range
// a stalled result holds the state machine; the queue keeps taking
// characters until it holds QueueDepth tokens
// -----------------------------------------------------------------------------
`default_nettype none

module srec_record_parser_core #(
   parameter int QueueDepth = srec_pkg::QUEUE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   srec_req_if.sink   req_chan,
   srec_rsp_if.source rsp_chan
);

   localparam int LvlW = $clog2(QueueDepth + 1);

   srec_pkg::token_type       push_token;
   srec_pkg::token_type       head_token;
   srec_pkg::back_status_type status;
   logic                      push_valid;
   logic                      queue_full;
   logic                      queue_not_empty;
   logic                      tok_pop;
   logic [LvlW - 1:0]         queue_level;

   srec_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_token (push_token),
      .push_valid (push_valid)
   );

   srec_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_token (push_token),
      .pop        (tok_pop),
      .head_token (head_token),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .level      (queue_level)
   );

   srec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (queue_not_empty),
      .tok       (head_token),
      .tok_pop   (tok_pop),
      .status    (status),
      .rsp_chan  (rsp_chan)
   );

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      queue_level <= LvlW'(QueueDepth))
      else $error("token queue over capacity");

   a_queue_count : assert property (@(posedge clock) disable iff (reset)
      (push_valid && !tok_pop) |=> (queue_level == $past(queue_level) + 1'b1))
      else $error("queue level did not track a push");

   a_eof_restart : assert property (@(posedge clock) disable iff (reset)
      (tok_pop && head_token.eof) |=>
         (!status.stopped && status.at_line_start && rsp_chan.valid))
      else $error("end of file did not restart the parser");

endmodule

`default_nettype wire
